// ===== design/nap_pkg.sv =====
// nap_pkg: shared types and constants for the network address parser
// no dependencies; imported by the interfaces, nap_parse and network_address_parser
`default_nettype none

package nap_pkg;

  // field widths fixed by the token format
  localparam int unsigned FIELD_W        = 16;
  localparam int unsigned ACC_W          = FIELD_W + 1;
  localparam int unsigned CH_W           = 8;
  localparam int unsigned OUTCOME_W      = 2;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned MAX_DIGITS_DEF = 5;

  // character codes
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;

  // outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_INVALID = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_NODE    = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_NET     = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUT_ZONE    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_ZONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_NET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_NODE = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            first;
  } nap_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] zone;
    logic [FIELD_W-1:0] net;
    logic [FIELD_W-1:0] node;
  } nap_defaults_t;

  typedef struct packed {
    logic [FIELD_W-1:0]   zone_out;
    logic [FIELD_W-1:0]   net_out;
    logic [FIELD_W-1:0]   node_out;
    logic [OUTCOME_W-1:0] outcome;
  } nap_result_t;

endpackage

`default_nettype wire

// ===== design/nap_if.sv =====
// nap_in_if / nap_out_if: valid-ready channels of the address parser
// depends on nap_pkg for field widths
`default_nettype none

interface nap_in_if
  import nap_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            first;

  modport source (output valid, output ch, output first, input ready);
  modport sink   (input valid, input ch, input first, output ready);
endinterface

interface nap_out_if
  import nap_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [FIELD_W-1:0]   zone_out;
  logic [FIELD_W-1:0]   net_out;
  logic [FIELD_W-1:0]   node_out;
  logic [OUTCOME_W-1:0] outcome;

  modport source (output valid, output zone_out, output net_out, output node_out,
                  output outcome, input ready);
  modport sink   (input valid, input zone_out, input net_out, input node_out,
                  input outcome, output ready);
endinterface

`default_nettype wire

// ===== design/network_address_parser.sv =====
// network_address_parser: top level, input register, default registers, parse stage
// depends on nap_pkg, nap_if (nap_in_if, nap_out_if) and nap_parse
//
// Parses address tokens of the form zone:net/node, one byte per transaction.
// Input channel in_chan carries ch and first; first marks a token's first byte
// and abandons any token in progress. Result channel out_chan carries
// zone_out, net_out, node_out and outcome (0 invalid, 1 node reached, 2 net
// set without node, 3 zone only); at most one result per input byte, given on
// the byte that decides the token. Bytes after that are dropped until first.
// The cfg port writes the default zone, net and node (index 0, 1, 2), which
// are picked up at a token's first byte; write them only while idle.
// Throughput: one byte per cycle while the receiver takes results. The parse
// step for a byte is combinational logic (multiply-by-ten add plus compares)
// between the input register and the result register; the byte is held in
// the input register and its result is registered in the result register.
// Reset (rst_n low, synchronous) empties both registers, returns the parser
// to waiting for a first byte and clears the defaults to zero.
// When the receiver stalls, the result holds; the input register still takes
// one more byte, and no further byte is taken until the result register
// drains.
`default_nettype none

module network_address_parser
  import nap_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  nap_in_if.sink                    in_chan,
  nap_out_if.source                 out_chan,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FIELD_W-1:0]   cfg_wdata
);

  logic          s1_valid_r, s1_valid_nxt;
  nap_item_t     s1_item_r;
  nap_defaults_t defaults_r;
  logic          take, accept;
  nap_result_t   result;
  logic          res_valid;

  // input register handshake
  assign in_chan.ready = !s1_valid_r || take;
  assign accept        = in_chan.valid && in_chan.ready;
  assign s1_valid_nxt  = accept ? 1'b1 : (take ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (accept) begin
      s1_item_r.ch    <= in_chan.ch;
      s1_item_r.first <= in_chan.first;
    end
  end

  // default field registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      defaults_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEF_ZONE: defaults_r.zone <= cfg_wdata;
        CFG_DEF_NET:  defaults_r.net  <= cfg_wdata;
        CFG_DEF_NODE: defaults_r.node <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // parse stage
  nap_parse #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .item       (s1_item_r),
    .defaults   (defaults_r),
    .out_ready  (out_chan.ready),
    .take       (take),
    .out_valid  (res_valid),
    .result     (result)
  );

  // result channel
  assign out_chan.valid    = res_valid;
  assign out_chan.zone_out = result.zone_out;
  assign out_chan.net_out  = result.net_out;
  assign out_chan.node_out = result.node_out;
  assign out_chan.outcome  = result.outcome;

endmodule

`default_nettype wire

// ===== design/nap_parse.sv =====
// nap_parse: per-byte parse step, token state registers and result register
// depends on nap_pkg
`default_nettype none

module nap_parse
  import nap_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          item_valid,
  input  wire nap_item_t     item,
  input  wire nap_defaults_t defaults,
  input  wire logic          out_ready,
  output logic               take,
  output logic               out_valid,
  output nap_result_t        result
);

  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FIRST,
    PH_NET,
    PH_NODE_A,
    PH_NODE_B
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [ACC_W-1:0]     accum_r, accum_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [FIELD_W-1:0]   zone_r, zone_nxt;
  logic [FIELD_W-1:0]   net_r, net_nxt;
  logic [FIELD_W-1:0]   node_r, node_nxt;
  logic [OUTCOME_W-1:0] code_r, code_nxt;
  logic                 out_valid_r, out_valid_nxt;
  nap_result_t          res_r;

  logic               is_dig, is_term, can_take, ovf, emit;
  logic [ACC_W-1:0]   digit_val, acc_inc;

  // character classes
  assign is_dig    = item.ch inside {[CH_ZERO:CH_NINE]};
  assign is_term   = (item.ch <= CH_SPACE) || item.ch[CH_W-1];
  assign digit_val = ACC_W'(item.ch - CH_ZERO) & ACC_W'(4'hF);

  // the output slot frees up when it is empty or being drained
  assign take = item_valid && (!out_valid_r || out_ready);

  // one parse step
  always_comb begin
    phase_nxt = phase_r;
    accum_nxt = accum_r;
    cnt_nxt   = cnt_r;
    zone_nxt  = zone_r;
    net_nxt   = net_r;
    node_nxt  = node_r;
    code_nxt  = code_r;
    emit      = 1'b0;

    // new token: load defaults, bad first byte fails at once
    if (item.first) begin
      zone_nxt  = defaults.zone;
      net_nxt   = defaults.net;
      node_nxt  = defaults.node;
      code_nxt  = OUT_INVALID;
      accum_nxt = '0;
      cnt_nxt   = '0;
      if (!is_dig) begin
        emit = 1'b1;
      end else begin
        phase_nxt = PH_FIRST;
      end
    end

    can_take = is_dig && (cnt_nxt < CNT_MAX);
    ovf      = accum_nxt[ACC_W-1];
    acc_inc  = (accum_nxt << 3) + (accum_nxt << 1) + digit_val;

    if (!emit) begin
      case (phase_nxt)
        PH_FIRST: begin
          if (can_take) begin
            accum_nxt = acc_inc;
            cnt_nxt   = cnt_nxt + 1'b1;
          end else if (item.ch == CH_COLON && !ovf) begin
            zone_nxt  = accum_nxt[FIELD_W-1:0];
            code_nxt  = OUT_ZONE;
            accum_nxt = '0;
            cnt_nxt   = '0;
            phase_nxt = PH_NET;
          end else if (item.ch == CH_SLASH && !ovf) begin
            net_nxt   = accum_nxt[FIELD_W-1:0];
            code_nxt  = OUT_NET;
            accum_nxt = '0;
            cnt_nxt   = '0;
            phase_nxt = PH_NODE_A;
          end else if (is_term && !ovf) begin
            node_nxt = accum_nxt[FIELD_W-1:0];
            code_nxt = OUT_NODE;
            emit     = 1'b1;
          end else begin
            code_nxt = OUT_INVALID;
            emit     = 1'b1;
          end
        end
        PH_NET: begin
          if (can_take) begin
            accum_nxt = acc_inc;
            cnt_nxt   = cnt_nxt + 1'b1;
          end else if (item.ch == CH_SLASH && !ovf) begin
            net_nxt   = accum_nxt[FIELD_W-1:0];
            code_nxt  = OUT_NET;
            accum_nxt = '0;
            cnt_nxt   = '0;
            phase_nxt = PH_NODE_B;
          end else begin
            code_nxt = OUT_ZONE;
            emit     = 1'b1;
          end
        end
        PH_NODE_A: begin
          if (can_take) begin
            accum_nxt = acc_inc;
            cnt_nxt   = cnt_nxt + 1'b1;
          end else if (is_term && !ovf) begin
            node_nxt = accum_nxt[FIELD_W-1:0];
            code_nxt = OUT_NODE;
            emit     = 1'b1;
          end else begin
            // failed byte starts a fresh node field
            phase_nxt = PH_NODE_B;
            if (is_dig) begin
              accum_nxt = digit_val;
              cnt_nxt   = CNT_W'(1);
            end else if (is_term) begin
              node_nxt = '0;
              code_nxt = OUT_NODE;
              emit     = 1'b1;
            end else begin
              code_nxt = OUT_NET;
              emit     = 1'b1;
            end
          end
        end
        PH_NODE_B: begin
          if (can_take) begin
            accum_nxt = acc_inc;
            cnt_nxt   = cnt_nxt + 1'b1;
          end else if (is_term && !ovf) begin
            node_nxt = accum_nxt[FIELD_W-1:0];
            code_nxt = OUT_NODE;
            emit     = 1'b1;
          end else begin
            code_nxt = OUT_NET;
            emit     = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // a decided token returns to idle
    if (emit) begin
      phase_nxt = PH_IDLE;
      accum_nxt = '0;
      cnt_nxt   = '0;
    end

    out_valid_nxt = (take && emit) ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      accum_r     <= '0;
      cnt_r       <= '0;
      zone_r      <= '0;
      net_r       <= '0;
      node_r      <= '0;
      code_r      <= OUT_INVALID;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        phase_r <= phase_nxt;
        accum_r <= accum_nxt;
        cnt_r   <= cnt_nxt;
        zone_r  <= zone_nxt;
        net_r   <= net_nxt;
        node_r  <= node_nxt;
        code_r  <= code_nxt;
      end
    end
    if (take && emit) begin
      res_r.zone_out <= zone_nxt;
      res_r.net_out  <= net_nxt;
      res_r.node_out <= node_nxt;
      res_r.outcome  <= code_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

  // idle leaves no partial field behind
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (accum_r == '0 && cnt_r == '0))
    else $error("idle phase with partial field");

  // digit count never passes the limit
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("digit count beyond limit");

  // a non-digit first byte is reported invalid in the next cycle
  a_bad_first: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item.first && !is_dig) |=> (out_valid_r && res_r.outcome == OUT_INVALID))
    else $error("bad first byte not reported");

  // a new result only appears for a consumed transaction
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(take))
    else $error("result without transaction");

endmodule

`default_nettype wire

// ===== sim/nap_result_checker.sv =====
// nap_result_checker: watches the address parser channels and the cfg port,
// predicts each result from the accepted bytes and compares them in order
// depends on nap_pkg and the nap_in_if / nap_out_if interfaces
module nap_result_checker
  import nap_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  nap_in_if                    in_mon,
  nap_out_if                   out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_wdata,
  output int unsigned          fail_count,
  output int unsigned          open_count,
  output int unsigned          byte_count,
  output int unsigned          result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_IDLE, PH_FIRST, PH_NET, PH_NODE_A, PH_NODE_B
  } parse_phase_t;

  localparam logic [ACC_W-1:0] FIELD_LIMIT = 17'h0FFFF;

  // shadow parser state
  parse_phase_t     phase;
  logic [ACC_W-1:0] accum;
  int unsigned      ndigits;
  nap_defaults_t    defaults;
  nap_result_t      held;

  nap_result_t      addr_q[$];
  int unsigned      fails;
  int unsigned      bytes_seen;
  int unsigned      results_seen;

  function automatic bit is_digit(input logic [CH_W-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // control bytes, space and anything with the top bit set end a token
  function automatic bit is_term(input logic [CH_W-1:0] c);
    return c <= CH_SPACE || c[CH_W-1];
  endfunction

  function automatic void clear_field();
    accum   = '0;
    ndigits = 0;
  endfunction

  function automatic bit take_digit(input logic [CH_W-1:0] c);
    if (!is_digit(c) || ndigits >= MAX_DIGITS_DEF) return 1'b0;
    accum = ACC_W'(accum * 10 + (c - CH_ZERO));
    ndigits++;
    return 1'b1;
  endfunction

  function automatic bit close_token(output nap_result_t r);
    r     = held;
    phase = PH_IDLE;
    clear_field();
    return 1'b1;
  endfunction

  // node field after net/ (or the retry after a failed first-field node)
  function automatic bit node_tail(input logic [CH_W-1:0] c, output nap_result_t r);
    if (take_digit(c)) return 1'b0;
    if (is_term(c) && accum <= FIELD_LIMIT) begin
      held.node_out = accum[FIELD_W-1:0];
      held.outcome  = OUT_NODE;
    end else begin
      held.outcome = OUT_NET;
    end
    return close_token(r);
  endfunction

  // one byte of the token; returns 1 when it decides the address
  function automatic bit parse_addr_byte(input logic [CH_W-1:0] c, input logic first,
                                         output nap_result_t r);
    bit fits;
    if (first) begin
      held.zone_out = defaults.zone;
      held.net_out  = defaults.net;
      held.node_out = defaults.node;
      held.outcome  = OUT_INVALID;
      clear_field();
      if (!is_digit(c)) return close_token(r);
      phase = PH_FIRST;
    end
    case (phase)
      PH_IDLE:   return 1'b0;
      PH_NODE_B: return node_tail(c, r);
      default:   ;
    endcase
    if (take_digit(c)) return 1'b0;
    fits = (accum <= FIELD_LIMIT);
    case (phase)
      PH_FIRST: begin
        if (c == CH_COLON && fits) begin
          held.zone_out = accum[FIELD_W-1:0];
          held.outcome  = OUT_ZONE;
          clear_field();
          phase = PH_NET;
          return 1'b0;
        end
        if (c == CH_SLASH && fits) begin
          held.net_out = accum[FIELD_W-1:0];
          held.outcome = OUT_NET;
          clear_field();
          phase = PH_NODE_A;
          return 1'b0;
        end
        if (is_term(c) && fits) begin
          held.node_out = accum[FIELD_W-1:0];
          held.outcome  = OUT_NODE;
          return close_token(r);
        end
        held.outcome = OUT_INVALID;
        return close_token(r);
      end
      PH_NET: begin
        if (c == CH_SLASH && fits) begin
          held.net_out = accum[FIELD_W-1:0];
          held.outcome = OUT_NET;
          clear_field();
          phase = PH_NODE_B;
          return 1'b0;
        end
        held.outcome = OUT_ZONE;
        return close_token(r);
      end
      default: begin
        // node after a first-field net: a failing byte is looked at again
        if (is_term(c) && fits) begin
          held.node_out = accum[FIELD_W-1:0];
          held.outcome  = OUT_NODE;
          return close_token(r);
        end
        clear_field();
        phase = PH_NODE_B;
        return node_tail(c, r);
      end
    endcase
  endfunction

  function automatic void flag(input string what, input nap_result_t want,
                               input nap_result_t got);
    fails++;
    if (fails <= 10)
      $display({"%0t %s: expected zone %0d net %0d node %0d outcome %0d,",
                " got zone %0d net %0d node %0d outcome %0d"},
               $time, what, want.zone_out, want.net_out, want.node_out, want.outcome,
               got.zone_out, got.net_out, got.node_out, got.outcome);
  endfunction

  // sample both channels and the cfg port at each rising edge
  always @(posedge clk) begin
    nap_result_t got, want, fresh;
    if (!rst_n) begin
      phase    = PH_IDLE;
      clear_field();
      held     = '0;
      defaults = '0;
      addr_q.delete();
      fails        = 0;
      bytes_seen   = 0;
      results_seen = 0;
    end else begin
      // result transaction against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got.zone_out = out_mon.zone_out;
        got.net_out  = out_mon.net_out;
        got.node_out = out_mon.node_out;
        got.outcome  = out_mon.outcome;
        results_seen++;
        if (addr_q.size() == 0) begin
          flag("result with nothing pending", '0, got);
        end else begin
          want = addr_q.pop_front();
          if (got.zone_out !== want.zone_out || got.net_out !== want.net_out ||
              got.node_out !== want.node_out || got.outcome !== want.outcome)
            flag("result mismatch", want, got);
        end
      end
      // default register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEF_ZONE: defaults.zone = cfg_wdata;
          CFG_DEF_NET:  defaults.net  = cfg_wdata;
          CFG_DEF_NODE: defaults.node = cfg_wdata;
          default:      ;
        endcase
      end
      // input transaction
      if (in_mon.valid && in_mon.ready) begin
        bytes_seen++;
        if (parse_addr_byte(in_mon.ch, in_mon.first, fresh)) addr_q.push_back(fresh);
      end
    end
    fail_count   <= fails;
    open_count   <= addr_q.size();
    byte_count   <= bytes_seen;
    result_count <= results_seen;
  end

endmodule

// ===== sim/network_address_parser_tb.sv =====
// network_address_parser_tb: clock, reset, byte stimulus and verdict
// depends on nap_pkg, nap_if, network_address_parser and nap_result_checker
module network_address_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nap_pkg::*;

  localparam real         CLK_PERIOD   = 12.0;
  localparam int unsigned LIMIT_CYCLES = 400_000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FIELD_W-1:0]   cfg_wdata;

  int unsigned fail_count, open_count, byte_count, result_count;
  int unsigned sent_items, token_count, setting_count;
  bit          starting, no_gaps;

  nap_in_if  in_chan ();
  nap_out_if out_chan ();

  network_address_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  nap_result_checker check_u (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .open_count   (open_count),
    .byte_count   (byte_count),
    .result_count (result_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // mostly short pauses, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one input transaction; returns at the edge that accepted it
  task automatic send_byte(input logic [CH_W-1:0] c);
    int unsigned gap;
    gap = no_gaps ? 0 : idle_len();
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.ch    <= c;
    in_chan.first <= starting;
    starting = 1'b0;
    sent_items++;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic send_text(input string s);
    int i;
    starting = 1'b1;
    token_count++;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // digit run: mostly short, many at five digits, some too long
  task automatic send_field();
    int unsigned r, n, value, scale;
    r = $urandom_range(0, 99);
    if (r < 5) n = 0;
    else if (r < 60) n = $urandom_range(1, 4);
    else if (r < 88) n = 5;
    else n = $urandom_range(6, 7);
    if (n == 5 && $urandom_range(0, 1) == 1) begin
      // values around the 16-bit limit
      value = ($urandom_range(0, 1) == 1) ? $urandom_range(65525, 65545)
                                           : $urandom_range(60000, 99999);
      scale = 10000;
      repeat (5) begin
        send_byte(CH_ZERO + 8'((value / scale) % 10));
        scale = scale / 10;
      end
    end else begin
      repeat (n) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  // separator, occasionally replaced by a random byte
  task automatic send_sep(input logic [CH_W-1:0] c);
    send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : c);
  endtask

  task automatic random_token();
    int unsigned form, n, r, keep;
    logic [CH_W-1:0] term;
    starting = 1'b1;
    token_count++;
    if ($urandom_range(0, 19) == 0) no_gaps = !no_gaps;
    form = $urandom_range(0, 99);
    if (form < 8) begin
      // raw noise, the first byte still opens a token
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom));
      return;
    end
    send_field();
    if (form < 30) begin
      // node only
    end else if (form < 60) begin
      send_sep(CH_SLASH);
      send_field();
    end else if (form < 85) begin
      send_sep(CH_COLON);
      send_field();
      send_sep(CH_SLASH);
      send_field();
    end else begin
      send_sep(CH_COLON);
      send_field();
    end
    // some tokens are abandoned by the next first byte
    if ($urandom_range(0, 9) == 0) return;
    r = $urandom_range(0, 9);
    if (r < 6) term = CH_SPACE;
    else if (r < 8) term = 8'($urandom_range(0, 32));
    else term = 8'($urandom_range(128, 255));
    send_byte(term);
    // trailing bytes the parser drops; not counted as items
    if ($urandom_range(0, 6) == 0) begin
      keep = sent_items;
      n = $urandom_range(1, 3);
      repeat (n) send_byte(8'($urandom));
      sent_items = keep;
    end
  endtask

  task automatic write_defaults(input nap_defaults_t d);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEF_ZONE;
    cfg_wdata <= d.zone;
    @(posedge clk);
    cfg_index <= CFG_DEF_NET;
    cfg_wdata <= d.net;
    @(posedge clk);
    cfg_index <= CFG_DEF_NODE;
    cfg_wdata <= d.node;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    setting_count++;
  endtask

  // wait for every predicted result, then let the pipeline empty
  task automatic settle();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
    repeat (4) @(posedge clk);
  endtask

  // result side backpressure with steady stretches
  initial begin : ready_gen
    int unsigned hold, steady_left, r;
    hold        = 0;
    steady_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (steady_left != 0) begin
        steady_left--;
        out_chan.ready <= 1'b1;
      end else if (hold != 0) begin
        hold--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        r = $urandom_range(0, 99);
        if (r < 3) steady_left = $urandom_range(50, 200);
        else if (r < 30) hold = idle_len();
      end
    end
  end

  // stimulus and verdict
  initial begin : stim
    nap_defaults_t d;
    int unsigned   target;
    in_chan.valid <= 1'b0;
    in_chan.ch    <= '0;
    in_chan.first <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_DEF_ZONE;
    cfg_wdata     <= '0;
    rst_n         <= 1'b0;
    sent_items    = 0;
    token_count   = 0;
    setting_count = 0;
    no_gaps       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed tokens
    d.zone = 16'hFFFF;
    d.net  = 16'h0000;
    d.node = 16'hFFFF;
    write_defaults(d);
    send_text("/");          // not a digit up front
    send_text("65535");      // largest node, ended by a byte with the top bit set
    send_byte(8'hFF);
    send_text("0:/9");       // empty net field, NUL terminator
    send_byte(8'h00);
    send_text("123456");     // sixth digit lands on the separator check
    send_text("1:x");        // zone set, net fails
    send_text("2/99999 ");   // oversized node re-read as an empty node
    settle();

    // random tokens under several default settings
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       d = '0;
        1:       d = '1;
        default: begin
          d.zone = 16'($urandom_range(0, 65535));
          d.net  = 16'($urandom_range(0, 65535));
          d.node = 16'($urandom_range(0, 65535));
        end
      endcase
      write_defaults(d);
      no_gaps = (p == 2);
      target  = sent_items + 80;
      while (sent_items < target) random_token();
      settle();
    end

    $display("summary: %0d bytes in %0d tokens under %0d default settings",
             byte_count, token_count, setting_count);
    $display("summary: %0d results checked, %0d failures", result_count, fail_count);
    if (fail_count == 0 && open_count == 0) begin
      $display("network_address_parser_tb: done, clean");
    end else begin
      $display("network_address_parser_tb: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("network_address_parser_tb: done, errors");
    $finish;
  end

endmodule
